>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the handle table checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table assertion failed");

`endif

>>> rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// types and constants shared by the outstanding handle table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

    localparam int ENTRIES  = 16;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int HANDLE_W = 8;
    localparam int EP_W     = 8;
    localparam int EXP_W    = 16;
    localparam int ENTRY_W  = HANDLE_W + EP_W + EXP_W;

    localparam logic [EXP_W-1:0] INTERVAL_RESET = 16'd10;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_TIMEOUT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [EP_W-1:0]     endpoint;
        logic [EXP_W-1:0]    expiry;
    } t_entry;

    typedef struct packed {
        t_kind               kind;
        logic                status;
        logic [HANDLE_W-1:0] handle;
        logic [EP_W-1:0]     endpoint;
        logic                last;
    } t_res;

endpackage

>>> rtl/core/cht_req_if.sv
// ----------------------------------------------------------------------------
// cht_req_if
// request channel: operation, handle and source endpoint
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cht_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] handle;
    logic [7:0] src_endpoint;

    modport source (output valid, output operation, output handle, output src_endpoint,
                    input ready);
    modport sink (input valid, input operation, input handle, input src_endpoint,
                  output ready);
endinterface

>>> rtl/core/cht_rsp_if.sv
// ----------------------------------------------------------------------------
// cht_rsp_if
// result channel: kind, status, handle, endpoint and last marker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cht_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       status;
    logic [7:0] handle_out;
    logic [7:0] endpoint_out;
    logic       last;

    modport source (output valid, output kind, output status, output handle_out,
                    output endpoint_out, output last, input ready);
    modport sink (input valid, input kind, input status, input handle_out,
                  input endpoint_out, input last, output ready);
endinterface

>>> rtl/core/cht_cfg_if.sv
// ----------------------------------------------------------------------------
// cht_cfg_if
// configuration write channel for the confirm interval
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cht_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cht_out_stage.sv
// ----------------------------------------------------------------------------
// cht_out_stage
// output register that holds one result word until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cht_pkg::t_res     i_res,
    output logic              o_free,
    cht_rsp_if.source         o_rsp
);

    logic          r_valid;
    logic          n_valid;
    cht_pkg::t_res r_res;

    assign o_free = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
        if (i_push) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.kind         = r_res.kind;
    assign o_rsp.status       = r_res.status;
    assign o_rsp.handle_out   = r_res.handle;
    assign o_rsp.endpoint_out = r_res.endpoint;
    assign o_rsp.last         = r_res.last;

endmodule

>>> rtl/core/confirm_handle_timeout_table_core.sv
// ----------------------------------------------------------------------------
// confirm_handle_timeout_table_core
// outstanding request handle table with per-entry expiry and tick timeouts
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | word per
//  i_req    | in  | operation, handle, src_endpoint                | operation
//  o_rsp    | out | kind, status, handle_out, endpoint_out, last   | result
//  i_cfg    | in  | data (confirm interval)                        | register write
//
//  add writes the entry directly; lookup, remove and tick walk the entries held,
//  and a new operation is accepted only once the previous one has finished
//  the walk visits the age-ordered slot list and the entry memory, each with a
//  registered read, one list position after the other
//  reset clears the valid flags and the entry count at once, no clearing pass
//  a full output register holds the walk in place until the word can move
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module confirm_handle_timeout_table_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp,
    cht_cfg_if.sink   i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_RDORD = 6'b000100,
        S_RDENT = 6'b001000,
        S_EVAL  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                               r_state, n_state;
    logic [cht_pkg::CNT_W-1:0]            r_cnt, n_cnt;
    logic [cht_pkg::ENTRIES-1:0]          r_valid, n_valid;
    logic [cht_pkg::EXP_W-1:0]            r_interval, n_interval;

    cht_pkg::t_op                         r_op, n_op;
    logic [cht_pkg::HANDLE_W-1:0]         r_h, n_h;
    logic [cht_pkg::EP_W-1:0]             r_ep, n_ep;
    logic [cht_pkg::CNT_W-1:0]            r_pos, n_pos;
    logic [cht_pkg::CNT_W-1:0]            r_wr, n_wr;
    logic                                 r_found, n_found;
    logic                                 r_pend_v, n_pend_v;
    cht_pkg::t_res                        r_pend, n_pend;
    logic [cht_pkg::SLOT_W-1:0]           r_slot, n_slot;

    logic                                 req_acc;
    logic [cht_pkg::SLOT_W-1:0]           free_slot;
    logic [cht_pkg::CNT_W-1:0]            pos_next;
    logic                                 hit;
    logic                                 adv;
    cht_pkg::t_kind                       op_kind;

    logic                                 ord_we, ord_re;
    logic [cht_pkg::SLOT_W-1:0]           ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic                                 ent_we, ent_re;
    logic [cht_pkg::SLOT_W-1:0]           ent_waddr, ent_raddr;
    cht_pkg::t_entry                      ent_wdata, ent_rdata;
    logic [cht_pkg::ENTRY_W-1:0]          ent_rdata_raw;

    logic                                 push;
    cht_pkg::t_res                        push_res;
    logic                                 out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign n_interval  = i_cfg.valid ? i_cfg.data : r_interval;

    assign ent_rdata = cht_pkg::t_entry'(ent_rdata_raw);
    assign pos_next  = r_pos + 1'b1;
    assign hit       = (ent_rdata.handle == r_h) && !r_found;
    assign op_kind   = (r_op == cht_pkg::OP_LOOKUP) ? cht_pkg::KIND_LOOKUP
                                                     : cht_pkg::KIND_REMOVE;

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = cht_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = cht_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_valid  = r_valid;
        n_op     = r_op;
        n_h      = r_h;
        n_ep     = r_ep;
        n_pos    = r_pos;
        n_wr     = r_wr;
        n_found  = r_found;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_slot   = r_slot;
        adv      = 1'b0;

        ord_we    = 1'b0;
        ord_waddr = r_wr[cht_pkg::SLOT_W-1:0];
        ord_wdata = r_slot;
        ord_re    = 1'b0;
        ord_raddr = r_pos[cht_pkg::SLOT_W-1:0];
        ent_we    = 1'b0;
        ent_waddr = r_slot;
        ent_wdata = ent_rdata;
        ent_re    = 1'b0;
        ent_raddr = ord_rdata;

        push              = 1'b0;
        push_res.kind     = op_kind;
        push_res.status   = 1'b0;
        push_res.handle   = r_h;
        push_res.endpoint = ent_rdata.endpoint;
        push_res.last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_op     = cht_pkg::t_op'(i_req.operation);
                    n_h      = i_req.handle;
                    n_ep     = i_req.src_endpoint;
                    n_pos    = '0;
                    n_wr     = '0;
                    n_found  = 1'b0;
                    n_pend_v = 1'b0;
                    if (cht_pkg::t_op'(i_req.operation) == cht_pkg::OP_ADD) begin
                        n_state = S_ADD;
                    end else if (r_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RDORD;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.kind = cht_pkg::KIND_ADD;
                    if (r_cnt == cht_pkg::CNT_W'(cht_pkg::ENTRIES)) begin
                        push_res.status   = 1'b1;
                        push_res.endpoint = '0;
                    end else begin
                        push_res.endpoint = r_ep;
                        ent_we            = 1'b1;
                        ent_waddr         = free_slot;
                        ent_wdata.handle   = r_h;
                        ent_wdata.endpoint = r_ep;
                        ent_wdata.expiry   = r_interval;
                        // new entry goes to the young end of the age list
                        ord_we             = 1'b1;
                        ord_waddr          = r_cnt[cht_pkg::SLOT_W-1:0];
                        ord_wdata          = free_slot;
                        n_valid[free_slot] = 1'b1;
                        n_cnt              = r_cnt + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RDORD: begin
                ord_re  = 1'b1;
                n_state = S_RDENT;
            end
            S_RDENT: begin
                ent_re  = 1'b1;
                n_slot  = ord_rdata;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_op)
                    cht_pkg::OP_LOOKUP: begin
                        if (hit) begin
                            if (out_free) begin
                                push    = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    cht_pkg::OP_REMOVE: begin
                        if (hit) begin
                            if (out_free) begin
                                push            = 1'b1;
                                n_found         = 1'b1;
                                n_valid[r_slot] = 1'b0;
                                adv             = 1'b1;
                            end
                        end else begin
                            // keep, closing the gap left by a removed entry
                            ord_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                            adv    = 1'b1;
                        end
                    end
                    cht_pkg::OP_TICK: begin
                        if (ent_rdata.expiry == '0) begin
                            // previous timeout is not the last one: send it now
                            if (!r_pend_v || out_free) begin
                                push              = r_pend_v;
                                push_res          = r_pend;
                                push_res.last     = 1'b0;
                                n_pend.kind       = cht_pkg::KIND_TIMEOUT;
                                n_pend.status     = 1'b0;
                                n_pend.handle     = ent_rdata.handle;
                                n_pend.endpoint   = ent_rdata.endpoint;
                                n_pend.last       = 1'b0;
                                n_pend_v          = 1'b1;
                                n_valid[r_slot]   = 1'b0;
                                adv               = 1'b1;
                            end
                        end else begin
                            ent_we           = 1'b1;
                            ent_wdata.expiry = ent_rdata.expiry - 1'b1;
                            ord_we           = 1'b1;
                            n_wr             = r_wr + 1'b1;
                            adv              = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase

                if (adv) begin
                    n_pos = pos_next;
                    if (pos_next == r_cnt) begin
                        n_state = S_DONE;
                    end else begin
                        // list write address stays below the next read address
                        ord_re    = 1'b1;
                        ord_raddr = pos_next[cht_pkg::SLOT_W-1:0];
                        n_state   = S_RDENT;
                    end
                end
            end
            S_DONE: begin
                case (r_op)
                    cht_pkg::OP_TICK: begin
                        if (!r_pend_v || out_free) begin
                            push          = r_pend_v;
                            push_res      = r_pend;
                            push_res.last = 1'b1;
                            n_cnt         = r_wr;
                            n_state       = S_IDLE;
                        end
                    end
                    cht_pkg::OP_LOOKUP, cht_pkg::OP_REMOVE: begin
                        if (r_found) begin
                            n_cnt   = r_wr;
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            push              = 1'b1;
                            push_res.status   = 1'b1;
                            push_res.endpoint = '0;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_valid    <= '0;
            r_interval <= cht_pkg::INTERVAL_RESET;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_valid    <= n_valid;
            r_interval <= n_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_h      <= n_h;
        r_ep     <= n_ep;
        r_pos    <= n_pos;
        r_wr     <= n_wr;
        r_found  <= n_found;
        r_pend_v <= n_pend_v;
        r_pend   <= n_pend;
        r_slot   <= n_slot;
    end

    // age-ordered list of occupied slots, oldest at position zero
    cht_ram #(
        .WIDTH (cht_pkg::SLOT_W),
        .DEPTH (cht_pkg::ENTRIES)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    cht_ram #(
        .WIDTH (cht_pkg::ENTRY_W),
        .DEPTH (cht_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata_raw)
    );

    cht_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

endmodule

>>> rtl/core/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// port-level checks on the handle table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_kind,
    input logic       i_rsp_status,
    input logic [7:0] i_rsp_handle,
    input logic [7:0] i_rsp_endpoint,
    input logic       i_rsp_last
);

    // a stalled result word holds
    `CHT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_kind) && $stable(i_rsp_handle) && $stable(i_rsp_endpoint) && $stable(i_rsp_last))

    // one operation at a time
    `CHT_ASSERT_NEXT(a_one_op, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // add, lookup and remove give exactly one word
    `CHT_ASSERT_SAME(a_single_last, i_clk, i_rst_n, i_rsp_valid && (i_rsp_kind != cht_pkg::KIND_TIMEOUT), i_rsp_last)

    // timeouts always report ok
    `CHT_ASSERT_SAME(a_timeout_ok, i_clk, i_rst_n, i_rsp_valid && (i_rsp_kind == cht_pkg::KIND_TIMEOUT), !i_rsp_status)

endmodule

bind confirm_handle_timeout_table_core cht_checker u_cht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_kind     (o_rsp.kind),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_handle   (o_rsp.handle_out),
    .i_rsp_endpoint (o_rsp.endpoint_out),
    .i_rsp_last     (o_rsp.last)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the outstanding handle table: a queued driver with
// bursty requests, a result monitor with its own stall pattern, and a table
// predictor checked word by word across several confirm interval settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF    = 4;
    localparam int SETTLE_CYC  = 2 * cht_pkg::ENTRIES + 8;
    localparam int WDOG_LIMIT  = 3000;
    localparam int POOL_MAX    = 24;

    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_SPARSE = 2;
    localparam int STALL_LONG   = 3;

    typedef struct {
        cht_pkg::t_op                 op;
        logic [cht_pkg::HANDLE_W-1:0] handle;
        logic [cht_pkg::EP_W-1:0]     src_ep;
    } t_req_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cht_req_if req_if ();
    cht_rsp_if rsp_if ();
    cht_cfg_if cfg_if ();

    confirm_handle_timeout_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predicted table contents
    logic                         tbl_valid  [cht_pkg::ENTRIES];
    logic [cht_pkg::HANDLE_W-1:0] tbl_handle [cht_pkg::ENTRIES];
    logic [cht_pkg::EP_W-1:0]     tbl_ep     [cht_pkg::ENTRIES];
    logic [cht_pkg::EXP_W-1:0]    tbl_expiry [cht_pkg::ENTRIES];
    int                           tbl_rank   [cht_pkg::ENTRIES];
    logic [cht_pkg::EXP_W-1:0]    interval_q;

    cht_pkg::t_res                expected_results [$];
    t_req_item                    op_backlog [$];
    logic [cht_pkg::HANDLE_W-1:0] live_handles [$];
    int        err_cnt = 0;
    logic      drv_holding = 1'b0;

    function automatic int count_held();
        int n;
        n = 0;
        for (int i = 0; i < cht_pkg::ENTRIES; i++)
            if (tbl_valid[i]) n++;
        return n;
    endfunction

    // renumber ages 0.. without gaps, keeping the present order
    function automatic void compact_ranks();
        int nr [cht_pkg::ENTRIES];
        for (int i = 0; i < cht_pkg::ENTRIES; i++) begin
            nr[i] = 0;
            for (int j = 0; j < cht_pkg::ENTRIES; j++)
                if (tbl_valid[i] && tbl_valid[j] && tbl_rank[j] < tbl_rank[i]) nr[i]++;
        end
        for (int i = 0; i < cht_pkg::ENTRIES; i++)
            if (tbl_valid[i]) tbl_rank[i] = nr[i];
    endfunction

    function automatic void apply_to_table(t_req_item it);
        int            slot;
        int            cnt;
        cht_pkg::t_res r;
        cht_pkg::t_res tq [$];
        r = '0;
        r.handle = it.handle;
        r.last   = 1'b1;
        slot     = -1;
        case (it.op)
            cht_pkg::OP_ADD: begin
                r.kind = cht_pkg::KIND_ADD;
                for (int i = 0; i < cht_pkg::ENTRIES; i++)
                    if (!tbl_valid[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    r.status = 1'b1;
                end else begin
                    cnt = count_held();
                    tbl_valid[slot]  = 1'b1;
                    tbl_handle[slot] = it.handle;
                    tbl_ep[slot]     = it.src_ep;
                    tbl_expiry[slot] = interval_q;
                    tbl_rank[slot]   = cnt;
                    r.endpoint       = it.src_ep;
                end
                expected_results.push_back(r);
            end
            cht_pkg::OP_LOOKUP, cht_pkg::OP_REMOVE: begin
                r.kind = (it.op == cht_pkg::OP_LOOKUP) ? cht_pkg::KIND_LOOKUP
                                                       : cht_pkg::KIND_REMOVE;
                for (int i = 0; i < cht_pkg::ENTRIES; i++)
                    if (tbl_valid[i] && tbl_handle[i] == it.handle &&
                        (slot < 0 || tbl_rank[i] < tbl_rank[slot])) slot = i;
                if (slot < 0) begin
                    r.status = 1'b1;
                end else begin
                    r.endpoint = tbl_ep[slot];
                    if (it.op == cht_pkg::OP_REMOVE) begin
                        tbl_valid[slot] = 1'b0;
                        compact_ranks();
                    end
                end
                expected_results.push_back(r);
            end
            default: begin
                // walk oldest to youngest; expired entries leave the table
                cnt = count_held();
                for (int rk = 0; rk < cnt; rk++) begin
                    slot = -1;
                    for (int i = 0; i < cht_pkg::ENTRIES; i++)
                        if (tbl_valid[i] && tbl_rank[i] == rk) slot = i;
                    if (slot >= 0) begin
                        if (tbl_expiry[slot] == '0) begin
                            r.kind     = cht_pkg::KIND_TIMEOUT;
                            r.status   = 1'b0;
                            r.handle   = tbl_handle[slot];
                            r.endpoint = tbl_ep[slot];
                            r.last     = 1'b0;
                            tq.push_back(r);
                            tbl_valid[slot] = 1'b0;
                        end else begin
                            tbl_expiry[slot] = tbl_expiry[slot] - 1'b1;
                        end
                    end
                end
                if (tq.size() > 0) begin
                    tq[tq.size()-1].last = 1'b1;
                    compact_ranks();
                end
                foreach (tq[k]) expected_results.push_back(tq[k]);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ------------------------------------------------------------------------
    t_req_item cur_item;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            req_if.valid        <= 1'b0;
            req_if.operation    <= cht_pkg::OP_ADD;
            req_if.handle       <= '0;
            req_if.src_endpoint <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_to_table(cur_item);
                drv_holding = 1'b0;
            end
            if (!drv_holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_backlog.size() > 0) begin
                    cur_item    = op_backlog.pop_front();
                    drv_holding = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            nv = drv_holding;
            req_if.valid <= nv;
            if (nv) begin
                req_if.operation    <= cur_item.op;
                req_if.handle       <= cur_item.handle;
                req_if.src_endpoint <= cur_item.src_ep;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result word, stall on a pattern of its own
    // ------------------------------------------------------------------------
    int stall_mode  = STALL_NONE;
    int stall_left  = 0;
    int sparse_k    = 1;
    int sparse_cnt  = 0;
    int long_run    = 0;

    always @(posedge i_clk) begin
        cht_pkg::t_res got;
        cht_pkg::t_res want;
        logic          nr;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.kind     = cht_pkg::t_kind'(rsp_if.kind);
            got.status   = rsp_if.status;
            got.handle   = rsp_if.handle_out;
            got.endpoint = rsp_if.endpoint_out;
            got.last     = rsp_if.last;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d handle %02h endpoint %02h",
                       got.kind, got.handle, got.endpoint);
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                    err_cnt++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.handle !== want.handle) begin
                    $error("handle_out: expected %02h, actual %02h", want.handle, got.handle);
                    err_cnt++;
                end
                if (got.endpoint !== want.endpoint) begin
                    $error("endpoint_out: expected %02h, actual %02h",
                           want.endpoint, got.endpoint);
                    err_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    err_cnt++;
                end
            end
        end

        if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
            stall_left = $urandom_range(20, 200);
            sparse_k   = $urandom_range(2, 6);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   nr = 1'b1;
            STALL_RANDOM: nr = 1'($urandom_range(0, 1));
            STALL_SPARSE: begin
                sparse_cnt = (sparse_cnt + 1) % sparse_k;
                nr = (sparse_cnt == 0);
            end
            default: begin
                if (long_run > 0) begin
                    long_run--;
                    nr = 1'b0;
                end else begin
                    nr = 1'b1;
                    if ($urandom_range(0, 9) == 0) long_run = $urandom_range(4, 20);
                end
            end
        endcase
        rsp_if.ready <= nr;
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any word moving on any channel
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_op(cht_pkg::t_op op, logic [cht_pkg::HANDLE_W-1:0] h,
                           logic [cht_pkg::EP_W-1:0] ep);
        t_req_item it;
        it.op     = op;
        it.handle = h;
        it.src_ep = ep;
        op_backlog.push_back(it);
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || drv_holding || expected_results.size() != 0)
            @(posedge i_clk);
        // a tick with nothing expired gives no word but still walks the table
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_interval(logic [cht_pkg::EXP_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        interval_q = v;
        cfg_if.valid <= 1'b0;
    endtask

    // adds of fresh or repeated handles, lookups and removes of mostly live
    // handles, and ticks, with some stray handles mixed in
    task automatic queue_random_ops(int count, int add_pct, int lookup_pct, int remove_pct);
        int                           roll;
        logic [cht_pkg::HANDLE_W-1:0] h;
        int                           idx;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (live_handles.size() > 0 && $urandom_range(0, 99) < 80) begin
                idx = $urandom_range(0, live_handles.size() - 1);
                h   = live_handles[idx];
            end else begin
                idx = -1;
                h   = 8'($urandom_range(0, 255));
            end
            if (roll < add_pct) begin
                if ($urandom_range(0, 3) != 0) h = 8'($urandom_range(0, 255));
                push_op(cht_pkg::OP_ADD, h, 8'($urandom_range(0, 255)));
                live_handles.push_back(h);
                if (live_handles.size() > POOL_MAX) void'(live_handles.pop_front());
            end else if (roll < add_pct + lookup_pct) begin
                push_op(cht_pkg::OP_LOOKUP, h, 8'($urandom_range(0, 255)));
            end else if (roll < add_pct + lookup_pct + remove_pct) begin
                push_op(cht_pkg::OP_REMOVE, h, 8'($urandom_range(0, 255)));
                if (idx >= 0) live_handles.delete(idx);
            end else begin
                push_op(cht_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= '0;

        interval_q = cht_pkg::INTERVAL_RESET;
        for (int i = 0; i < cht_pkg::ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_handle[i] = '0;
            tbl_ep[i]     = '0;
            tbl_expiry[i] = '0;
            tbl_rank[i]   = 0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, hits and misses, quiet tick
        push_op(cht_pkg::OP_ADD,    8'h00, 8'hFF);
        push_op(cht_pkg::OP_ADD,    8'hFF, 8'h00);
        push_op(cht_pkg::OP_ADD,    8'h00, 8'h5A);
        push_op(cht_pkg::OP_LOOKUP, 8'h00, 8'h00);
        push_op(cht_pkg::OP_LOOKUP, 8'h77, 8'hFF);
        push_op(cht_pkg::OP_REMOVE, 8'h00, 8'h00);
        push_op(cht_pkg::OP_LOOKUP, 8'h00, 8'h00);
        push_op(cht_pkg::OP_REMOVE, 8'h33, 8'h00);
        push_op(cht_pkg::OP_TICK,   8'hFF, 8'hFF);
        wait_drained();

        // zero interval: fill the table, overflow it, then time out the new ones
        write_interval(16'h0000);
        for (int i = 0; i < cht_pkg::ENTRIES - 2; i++)
            push_op(cht_pkg::OP_ADD, 8'(8'h10 + i), 8'(8'hA0 + i));
        push_op(cht_pkg::OP_ADD,  8'hEE, 8'h11);
        push_op(cht_pkg::OP_TICK, 8'h00, 8'h00);
        push_op(cht_pkg::OP_TICK, 8'h00, 8'h00);
        wait_drained();

        write_interval(16'hFFFF);
        queue_random_ops(49, 50, 20, 15);
        wait_drained();

        write_interval(16'h0001);
        queue_random_ops(49, 40, 15, 15);
        wait_drained();

        write_interval(16'h0000);
        queue_random_ops(49, 45, 15, 10);
        wait_drained();

        write_interval(16'($urandom_range(2, 30)));
        queue_random_ops(49, 35, 20, 15);
        wait_drained();

        write_interval(cht_pkg::INTERVAL_RESET);
        queue_random_ops(49, 40, 15, 15);
        wait_drained();

        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
